// File: rtl/c2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants of the chunky-to-planar packer
// Holds the field widths, register indexes, the group record that travels
// from the front end to the word serializer, and the plane count decode.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int unsigned MAX_PLANES  = 8;
    localparam int unsigned PIXEL_BITS  = 8;
    localparam int unsigned WORD_BITS   = 16;
    localparam int unsigned PLANE_BITS  = 3;
    localparam int unsigned MODE_BITS   = 2;
    localparam int unsigned COL_BITS    = 16;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned CFG_IDX_BITS  = 1;
    localparam int unsigned QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_MODE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH  = 1'b1;

    localparam logic [MODE_BITS-1:0] PLANE_MODE_RESET = 2'd3;
    localparam logic [COL_BITS-1:0]  ROW_WIDTH_RESET  = 16'd320;
    localparam logic [3:0]           GROUP_END_NIBBLE = 4'hF;

    typedef logic [WORD_BITS-1:0]   word_t;
    typedef logic [PLANE_BITS-1:0]  plane_t;
    typedef logic [MODE_BITS-1:0]   mode_t;

    // One finished group of sixteen pixels: every plane word plus the
    // number of the final plane to be sent.
    typedef struct packed {
        word_t [MAX_PLANES-1:0] words;
        plane_t                 last_plane;
    } group_t;

    // Final plane number for a mode, limited by the number of planes kept.
    function automatic plane_t last_plane_of(input mode_t mode);
        int unsigned n;
        n = 1 << mode;
        if (n > MAX_PLANES)
        begin
            n = MAX_PLANES;
        end
        return PLANE_BITS'(n - 1);
    endfunction

endpackage

// File: rtl/chunky_to_planar_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunky_to_planar_packer: palette pixels to interleaved bitplane words
// Top level: pixel intake, group queue and word serializer.
// ----------------------------------------------------------------------------
// The block takes one 8-bit palette pixel per cycle, row by row, and sends
// out 16-bit bitplane words. Every sixteenth pixel of a row closes a group,
// and the group's plane words follow on the output, plane 0 first, one word
// per cycle while word_ready is high, with last marking the final plane.
// plane_mode selects 1, 2, 4 or 8 planes and row_width the pixels per row
// (zero means 65536); a partial group at the end of a row is dropped. A
// pixel is taken every cycle; the only stall comes at a group end when both
// queue entries are occupied, which happens only if the output side has
// been held back, since a group of at most eight words drains faster than
// the next group of sixteen pixels is built. A closed group reaches the
// output through a queue entry and then the output register.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle; a mode change takes effect at the next group.
// ----------------------------------------------------------------------------
module chunky_to_planar_packer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [c2p_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [c2p_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [c2p_pkg::PIXEL_BITS-1:0]    pixel_index,
    output logic                              word_valid,
    input  logic                              word_ready,
    output logic [c2p_pkg::WORD_BITS-1:0]     plane_word,
    output logic [c2p_pkg::PLANE_BITS-1:0]    plane_number,
    output logic                              last
);
    import c2p_pkg::*;

    logic   push;
    group_t push_group;
    logic   queue_full;
    logic   pop;
    logic   head_valid;
    group_t head_group;

    // Intake: configuration, shift registers and column counter.
    c2p_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_index (pixel_index),
        .push        (push),
        .push_group  (push_group),
        .queue_full  (queue_full)
    );

    // Two finished groups can wait here while the output is stalled.
    c2p_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    // Serializer: one plane word per cycle into the output register, unless stalled.
    c2p_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_group   (head_group),
        .pop          (pop),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .plane_word   (plane_word),
        .plane_number (plane_number),
        .last         (last)
    );

    // A full queue must hold the intake off exactly at a group end.
    a_stall_only_at_group: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> queue_full)
        else $error("pixel intake stalled with room in the queue");

endmodule

// File: rtl/c2p_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_front: pixel intake and bitplane shifting
// Holds the configuration, the eight plane shift registers and the column
// counter, and hands each completed group of sixteen pixels to the queue.
// ----------------------------------------------------------------------------
module c2p_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [c2p_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [c2p_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [c2p_pkg::PIXEL_BITS-1:0]  pixel_index,
    output logic                            push,
    output c2p_pkg::group_t                 push_group,
    input  logic                            queue_full
);
    import c2p_pkg::*;

    word_t [PIXEL_BITS-1:0]  plane_shift_reg;
    word_t [PIXEL_BITS-1:0]  plane_shift_next;
    word_t [PIXEL_BITS-1:0]  shifted;
    logic [COL_BITS-1:0]     column_count_reg;
    logic [COL_BITS-1:0]     column_count_next;
    mode_t                   plane_mode_reg;
    logic [COL_BITS-1:0]     row_width_reg;
    logic [COL_BITS:0]       col_inc;
    logic [COL_BITS:0]       row_limit;
    logic                    group_end;
    logic                    row_end;
    logic                    accept;

    assign group_end   = (column_count_reg[3:0] == GROUP_END_NIBBLE);
    // A group end needs a free queue slot; other pixels never stall.
    assign pixel_ready = !queue_full || !group_end;
    assign accept      = pixel_valid && pixel_ready;

    assign col_inc   = {1'b0, column_count_reg} + {{COL_BITS{1'b0}}, 1'b1};
    // A row width of zero stands for a full 65536-pixel row.
    assign row_limit = (row_width_reg == '0) ? {1'b1, {COL_BITS{1'b0}}}
                                             : {1'b0, row_width_reg};
    assign row_end   = (col_inc >= row_limit);

    always_comb
    begin
        for (int k = 0; k < PIXEL_BITS; k++)
        begin
            shifted[k] = {plane_shift_reg[k][WORD_BITS-2:0], pixel_index[k]};
        end
    end

    assign push = accept && group_end;

    always_comb
    begin
        for (int k = 0; k < MAX_PLANES; k++)
        begin
            push_group.words[k] = shifted[k];
        end
        push_group.last_plane = last_plane_of(plane_mode_reg);
    end

    always_comb
    begin
        plane_shift_next  = plane_shift_reg;
        column_count_next = column_count_reg;
        if (accept)
        begin
            plane_shift_next = (group_end || row_end) ? '0 : shifted;
            column_count_next = row_end ? '0 : col_inc[COL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_shift_reg  <= '0;
            column_count_reg <= '0;
            plane_mode_reg   <= PLANE_MODE_RESET;
            row_width_reg    <= ROW_WIDTH_RESET;
        end
        else
        begin
            plane_shift_reg  <= plane_shift_next;
            column_count_reg <= column_count_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PLANE_MODE: plane_mode_reg <= cfg_data[MODE_BITS-1:0];
                    REG_ROW_WIDTH:  row_width_reg  <= cfg_data[COL_BITS-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // A group end that is accepted always goes to the queue.
    a_group_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && group_end) |-> push)
        else $error("group end accepted without a queue push");

    // After an accepted group end the shift registers start from zero.
    a_clear_after_group: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && group_end) |=> (plane_shift_reg == '0))
        else $error("plane shift registers not cleared after a group");

endmodule

// File: rtl/c2p_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_queue: group queue between intake and serializer
// A two-entry first-in first-out buffer of finished groups.
// ----------------------------------------------------------------------------
module c2p_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  c2p_pkg::group_t push_group,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output c2p_pkg::group_t head_group
);
    import c2p_pkg::*;

    group_t     entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_group = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full group queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty group queue");

endmodule

// File: rtl/c2p_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_back: plane word serializer
// Sends the words of the group at the queue head, plane 0 first, one word
// per cycle while the output is not stalled, through an output register,
// and retires the group after its final plane.
// ----------------------------------------------------------------------------
module c2p_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  c2p_pkg::group_t                 head_group,
    output logic                            pop,
    output logic                            word_valid,
    input  logic                            word_ready,
    output logic [c2p_pkg::WORD_BITS-1:0]   plane_word,
    output logic [c2p_pkg::PLANE_BITS-1:0]  plane_number,
    output logic                            last
);
    import c2p_pkg::*;

    plane_t idx_reg;
    plane_t idx_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    word_t  plane_word_reg;
    plane_t plane_number_reg;
    logic   last_reg;
    logic   issue;
    logic   final_plane;

    assign issue       = head_valid && (!out_valid_reg || word_ready);
    assign final_plane = (idx_reg == head_group.last_plane);
    assign pop         = issue && final_plane;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !word_ready;
        if (issue)
        begin
            out_valid_next = 1'b1;
            idx_next       = final_plane ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            plane_word_reg   <= head_group.words[idx_reg];
            plane_number_reg <= idx_reg;
            last_reg         <= final_plane;
        end
    end

    assign word_valid   = out_valid_reg;
    assign plane_word   = plane_word_reg;
    assign plane_number = plane_number_reg;
    assign last         = last_reg;

    // A retired group restarts the plane count at zero.
    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == '0))
        else $error("plane index not restarted after a group");

    // The plane index never runs past the group's final plane.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg <= head_group.last_plane))
        else $error("plane index beyond the final plane");

endmodule
